// ===== src/oafg_pkg.sv =====
// ----------------------------------------------------------------------------
// oafg_pkg
// Shared types and constants for the overlap-add frame glue block.
// ----------------------------------------------------------------------------
package oafg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP  = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd4096;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // saturation limits of the output samples
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // sine table generation, Q30
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // one classified sample as it travels through the queue
    typedef struct packed {
        logic                       is_store;   // second half of frame: store only
        logic                       half_last;  // last sample of its half
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } oafg_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } oafg_fifo_stat_t;

endpackage

// ===== src/oafg_if.sv =====
// ----------------------------------------------------------------------------
// oafg interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface oafg_sample_if;
    import oafg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface oafg_result_if;
    import oafg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic                       frame_last;
    logic                       clipped;

    modport source (output valid, output out_re, output out_im, output frame_last,
                    output clipped, input ready);
    modport sink   (input valid, input out_re, input out_im, input frame_last,
                    input clipped, output ready);
endinterface

interface oafg_cfg_if;
    import oafg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/oafg_front.sv =====
// ----------------------------------------------------------------------------
// oafg_front
// Accepts samples, tracks the position in the frame and tags each item as
// a first-half (glue) or second-half (store) sample.
// ----------------------------------------------------------------------------
module oafg_front #(
    parameter int HALF_LEN = 256,
    localparam int IDX_W = $clog2(HALF_LEN)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    oafg_sample_if.sink              samples,
    input  oafg_pkg::oafg_fifo_stat_t q_stat,
    output logic                     push,
    output oafg_pkg::oafg_item_t     push_item,
    output logic [IDX_W-1:0]         push_idx
);
    import oafg_pkg::*;

    localparam int POS_W = $clog2(2 * HALF_LEN);
    localparam logic [POS_W-1:0] POS_HALF     = POS_W'(HALF_LEN);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(2 * HALF_LEN - 1);
    localparam logic [POS_W-1:0] POS_HALF_END = POS_W'(HALF_LEN - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             is_store;
    logic [POS_W-1:0] rel_pos;

    assign samples.ready = !q_stat.full;
    assign push          = samples.valid && samples.ready;

    assign is_store = (pos_reg >= POS_HALF);
    assign rel_pos  = is_store ? (pos_reg - POS_HALF) : pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign push_item.is_store  = is_store;
    assign push_item.half_last = (rel_pos == POS_HALF_END);
    assign push_item.re        = samples.sample_re;
    assign push_item.im        = samples.sample_im;
    assign push_idx            = rel_pos[IDX_W-1:0];

endmodule

// ===== src/oafg_fifo.sv =====
// ----------------------------------------------------------------------------
// oafg_fifo
// Short register queue that decouples the front from the back pipeline.
// ----------------------------------------------------------------------------
module oafg_fifo #(
    parameter int WIDTH = 35
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          push_data,
    input  logic                      pop,
    output logic [WIDTH-1:0]          pop_data,
    output oafg_pkg::oafg_fifo_stat_t stat
);
    import oafg_pkg::*;

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/oafg_back.sv =====
// ----------------------------------------------------------------------------
// oafg_back
// Glue pipeline: half-frame store and weight ROM, weighting products,
// signed sum, gain, round and saturate, output register.
// ----------------------------------------------------------------------------
module oafg_back #(
    parameter int HALF_LEN    = 256,
    parameter int WINDOW_BITS = 16,
    localparam int IDX_W = $clog2(HALF_LEN)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [15:0]               gain,
    input  logic                      prewindowed,
    input  logic                      center_sign_flip,
    input  oafg_pkg::oafg_fifo_stat_t q_stat,
    output logic                      pop,
    input  oafg_pkg::oafg_item_t      item,
    input  logic [IDX_W-1:0]          idx,
    oafg_result_if.source             results
);
    import oafg_pkg::*;

    localparam int A_W    = WINDOW_BITS + 1;
    localparam int PROD_W = WINDOW_BITS + 18;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = SUM_W + 17;
    localparam int RES_W  = ACC_W + 1;
    localparam int SH     = WINDOW_BITS + 12;

    localparam logic [A_W-1:0]          A_ONE     = {1'b1, {WINDOW_BITS{1'b0}}};
    localparam logic signed [RES_W-1:0] RND_HALF  = RES_W'(1) << (SH - 1);
    localparam logic signed [RES_W-1:0] RES_MAX   = RES_W'(SAT_MAX);
    localparam logic signed [RES_W-1:0] RES_MIN   = RES_W'(SAT_MIN);
    localparam logic [63:0]             TWO_HALF  = 64'(2 * HALF_LEN);
    localparam logic [63:0]             SQ_RND    = 64'd1 << (59 - WINDOW_BITS);
    localparam logic [63:0]             W_ONE64   = 64'd1 << WINDOW_BITS;

    typedef logic [A_W-1:0] alpha_tab_t [HALF_LEN];

    // Q30 sine by a truncated Taylor series in Horner form
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] d;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 0; k < 6; k++)
        begin
            p = (x2 * t) >> 30;
            unique case (k)
                0:       d = p / 64'd156;
                1:       d = p / 64'd110;
                2:       d = p / 64'd72;
                3:       d = p / 64'd42;
                4:       d = p / 64'd20;
                default: d = p / 64'd6;
            endcase
            t = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
        end
        return (x * t) >> 30;
    endfunction

    // sin^2 weights, evaluated at elaboration
    function automatic alpha_tab_t build_alpha();
        alpha_tab_t  tab;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] sq;
        for (int i = 0; i < HALF_LEN; i++)
        begin
            x  = (64'(i) * PI_Q30) / TWO_HALF;
            s  = sine_q30(x);
            sq = (s * s + SQ_RND) >> (60 - WINDOW_BITS);
            if (sq > W_ONE64)
            begin
                sq = W_ONE64;
            end
            tab[i] = A_W'(sq);
        end
        return tab;
    endfunction

    localparam alpha_tab_t ALPHA_ROM = build_alpha();

    // {clip, value}
    function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [RES_W-1:0] r;
        r = (RES_W'(acc) + RND_HALF) >>> SH;
        priority if (r > RES_MAX)
        begin
            return {1'b1, SAT_MAX};
        end
        else if (r < RES_MIN)
        begin
            return {1'b1, SAT_MIN};
        end
        else
        begin
            return {1'b0, r[SAMPLE_W-1:0]};
        end
    endfunction

    logic advance;

    // half-frame store and its fill flag
    logic [31:0]    store_mem [HALF_LEN];
    logic [31:0]    store_rd_reg;
    logic [A_W-1:0] alpha_rd_reg;
    logic           store_ok_reg;
    logic           prev_sign_reg;

    // stage 1: store / ROM read
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_re_reg;
    logic signed [SAMPLE_W-1:0] s1_im_reg;
    logic                       s1_neg_cur_reg;
    logic                       s1_neg_prev_reg;
    logic                       s1_last_reg;
    logic                       s1_prev_ok_reg;

    // stage 2: weighting products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_tc_re_reg;
    logic signed [PROD_W-1:0] s2_tp_re_reg;
    logic signed [PROD_W-1:0] s2_tc_im_reg;
    logic signed [PROD_W-1:0] s2_tp_im_reg;
    logic                     s2_neg_cur_reg;
    logic                     s2_neg_prev_reg;
    logic                     s2_last_reg;

    // stage 3: signed sum
    logic                    s3_valid_reg;
    logic signed [SUM_W-1:0] s3_sum_re_reg;
    logic signed [SUM_W-1:0] s3_sum_im_reg;
    logic                    s3_last_reg;

    // stage 4: gain
    logic                    s4_valid_reg;
    logic signed [ACC_W-1:0] s4_acc_re_reg;
    logic signed [ACC_W-1:0] s4_acc_im_reg;
    logic                    s4_last_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_re_reg;
    logic signed [SAMPLE_W-1:0] out_im_reg;
    logic                       out_last_reg;
    logic                       out_clip_reg;

    logic [A_W-1:0]             a_sel;
    logic [A_W-1:0]             b_sel;
    logic signed [SAMPLE_W-1:0] prev_re;
    logic signed [SAMPLE_W-1:0] prev_im;
    logic signed [PROD_W-1:0]   tc_re;
    logic signed [PROD_W-1:0]   tp_re;
    logic signed [PROD_W-1:0]   tc_im;
    logic signed [PROD_W-1:0]   tp_im;
    logic signed [SUM_W-1:0]    sum_re;
    logic signed [SUM_W-1:0]    sum_im;
    logic signed [ACC_W-1:0]    acc_re;
    logic signed [ACC_W-1:0]    acc_im;
    logic [SAMPLE_W:0]          fin_re;
    logic [SAMPLE_W:0]          fin_im;

    // whole pipe moves together, held only by a full output register that is not taken
    assign advance = !out_valid_reg || results.ready;
    assign pop     = advance && !q_stat.empty;

    always_ff @(posedge clk)
    begin
        if (pop && item.is_store)
        begin
            store_mem[idx] <= {item.im, item.re};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            store_rd_reg <= store_mem[idx];
            alpha_rd_reg <= ALPHA_ROM[idx];
        end
    end

    // stage 2 products
    always_comb
    begin
        a_sel   = prewindowed ? A_ONE : alpha_rd_reg;
        b_sel   = prewindowed ? A_ONE : (A_ONE - alpha_rd_reg);
        prev_re = s1_prev_ok_reg ? $signed(store_rd_reg[15:0])  : '0;
        prev_im = s1_prev_ok_reg ? $signed(store_rd_reg[31:16]) : '0;
        tc_re   = PROD_W'($signed({1'b0, a_sel})) * PROD_W'(s1_re_reg);
        tp_re   = PROD_W'($signed({1'b0, b_sel})) * PROD_W'(prev_re);
        tc_im   = PROD_W'($signed({1'b0, a_sel})) * PROD_W'(s1_im_reg);
        tp_im   = PROD_W'($signed({1'b0, b_sel})) * PROD_W'(prev_im);
    end

    // stage 3 sum with centre signs, stage 4 gain, output rounding
    always_comb
    begin
        sum_re = (s2_neg_cur_reg  ? -SUM_W'(s2_tc_re_reg) : SUM_W'(s2_tc_re_reg))
               + (s2_neg_prev_reg ? -SUM_W'(s2_tp_re_reg) : SUM_W'(s2_tp_re_reg));
        sum_im = (s2_neg_cur_reg  ? -SUM_W'(s2_tc_im_reg) : SUM_W'(s2_tc_im_reg))
               + (s2_neg_prev_reg ? -SUM_W'(s2_tp_im_reg) : SUM_W'(s2_tp_im_reg));
        acc_re = ACC_W'(s3_sum_re_reg) * ACC_W'($signed({1'b0, gain}));
        acc_im = ACC_W'(s3_sum_im_reg) * ACC_W'($signed({1'b0, gain}));
        fin_re = round_sat(s4_acc_re_reg);
        fin_im = round_sat(s4_acc_im_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_ok_reg  <= 1'b0;
            prev_sign_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            // store counts as filled once the first full second half is in
            if (pop && item.is_store && item.half_last)
            begin
                store_ok_reg <= 1'b1;
            end
            if (pop && !item.is_store && item.half_last)
            begin
                prev_sign_reg <= center_sign_flip;
            end
            s1_valid_reg  <= pop && !item.is_store;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_re_reg       <= item.re;
            s1_im_reg       <= item.im;
            s1_neg_cur_reg  <= center_sign_flip;
            s1_neg_prev_reg <= prev_sign_reg;
            s1_last_reg     <= item.half_last;
            s1_prev_ok_reg  <= store_ok_reg;

            s2_tc_re_reg    <= tc_re;
            s2_tp_re_reg    <= tp_re;
            s2_tc_im_reg    <= tc_im;
            s2_tp_im_reg    <= tp_im;
            s2_neg_cur_reg  <= s1_neg_cur_reg;
            s2_neg_prev_reg <= s1_neg_prev_reg;
            s2_last_reg     <= s1_last_reg;

            s3_sum_re_reg   <= sum_re;
            s3_sum_im_reg   <= sum_im;
            s3_last_reg     <= s2_last_reg;

            s4_acc_re_reg   <= acc_re;
            s4_acc_im_reg   <= acc_im;
            s4_last_reg     <= s3_last_reg;

            if (s4_valid_reg)
            begin
                out_re_reg   <= $signed(fin_re[SAMPLE_W-1:0]);
                out_im_reg   <= $signed(fin_im[SAMPLE_W-1:0]);
                out_last_reg <= s4_last_reg;
                out_clip_reg <= fin_re[SAMPLE_W] || fin_im[SAMPLE_W];
            end
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_re     = out_re_reg;
    assign results.out_im     = out_im_reg;
    assign results.frame_last = out_last_reg;
    assign results.clipped    = out_clip_reg;

endmodule

// ===== src/overlap_add_frame_glue_core.sv =====
// ----------------------------------------------------------------------------
// overlap_add_frame_glue_core
// 50 percent overlap-add of inverse-FFT frames with sin^2 / cos^2 weights (or
// unit if prewindowed), centre-bin sign handling, gain, rounding, saturation.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | item
//  ---------+-----+---------------+-------------------------------------------
//  samples  | in  | valid / ready | sample_re, sample_im
//  results  | out | valid / ready | out_re, out_im, frame_last, clipped
//  cfg      | in  | valid / ready | index (0 gain, 1 prewindowed,
//           |     |               |        2 center_sign_flip), data
//
//  Sustained rate one sample per cycle while results are taken; a sample, once
//  accepted, passes in order through queue write, store/ROM read, products,
//  sum, gain and round/saturate into the output register.
//  First-half samples give one result each; second-half samples are stored.
//  Reset takes effect at once: the store reads as zero until the first full
//  second half has been written, so no clearing pass is needed.
//  A stalled result freezes the back pipeline; the four-entry queue then
//  fills and samples.ready drops. cfg.ready is always high.
// ----------------------------------------------------------------------------
module overlap_add_frame_glue_core #(
    parameter int HALF_LEN    = 256,
    parameter int WINDOW_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    oafg_cfg_if.sink      cfg,
    oafg_sample_if.sink   samples,
    oafg_result_if.source results
);
    import oafg_pkg::*;

    localparam int IDX_W = $clog2(HALF_LEN);
    localparam int Q_W   = $bits(oafg_item_t) + IDX_W;

    logic [15:0]     gain_reg;
    logic            early_reg;
    logic            flip_reg;

    logic            push;
    oafg_item_t      push_item;
    logic [IDX_W-1:0] push_idx;
    logic            pop;
    logic [Q_W-1:0]  pop_data;
    oafg_item_t      pop_item;
    logic [IDX_W-1:0] pop_idx;
    oafg_fifo_stat_t q_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            early_reg <= 1'b0;
            flip_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_GAIN:  gain_reg  <= cfg.data;
                CFG_EARLY: early_reg <= cfg.data[0];
                CFG_FLIP:  flip_reg  <= cfg.data[0];
                default:   ;
            endcase
        end
    end

    oafg_front #(
        .HALF_LEN (HALF_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item),
        .push_idx  (push_idx)
    );

    oafg_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_idx, push_item}),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    assign pop_item = pop_data[$bits(oafg_item_t)-1:0];
    assign pop_idx  = pop_data[Q_W-1:$bits(oafg_item_t)];

    oafg_back #(
        .HALF_LEN    (HALF_LEN),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .gain             (gain_reg),
        .prewindowed      (early_reg),
        .center_sign_flip (flip_reg),
        .q_stat           (q_stat),
        .pop              (pop),
        .item             (pop_item),
        .idx              (pop_idx),
        .results          (results)
    );

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("back popped an empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("front pushed into a full queue");

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.clipped) |->
            (results.out_re == SAT_MAX || results.out_re == SAT_MIN ||
             results.out_im == SAT_MAX || results.out_im == SAT_MIN))
        else $error("clipped item without a saturated part");

endmodule
